/* src/jacobi_linear_solver_top_assert.svh */
// Assertion macros for the Jacobi solver checker.
`ifndef JACOBI_LINEAR_SOLVER_TOP_ASSERT_SVH
`define JACOBI_LINEAR_SOLVER_TOP_ASSERT_SVH

// Clocked check, muted while reset is applied.
`define JLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset.
`define JLS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/jls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package jls_pkg;

  localparam int MAX_N     = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_N);
  localparam int MADDR_W   = 2 * IDX_W;
  localparam int DATA_W    = 32;
  localparam int ITER_W    = 16;
  localparam int SIZE_W    = 5;
  localparam int TOL_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = DATA_W + IDX_W + 2;
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int STAT_W    = 2;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_LD_MAT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LD_RHS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LD_X   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
  localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_DIAG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] solution;
    logic [ITER_W-1:0]        iterations;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic              load;
    logic              diag_rd;
    logic              row_rd;
    logic              out_rd;
    logic              out_last;
    logic              clr_solve;
    logic              clr_worst;
    logic              div_start;
    logic              upd;
    logic              flip;
    logic [IDX_W-1:0]  row_idx;
    logic [IDX_W-1:0]  col_idx;
    logic [STAT_W-1:0] stat;
    logic [ITER_W-1:0] iters;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_diag;
    logic pipe_empty;
    logic div_done;
    logic converged;
  } dp_stat_t;

  // Clamp a wide signed value into the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if ((&v[63:DATA_W-1]) || !(|v[63:DATA_W-1])) begin
      return v[DATA_W-1:0];
    end
    return v[63] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

/* src/jls_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module jls_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* src/jls_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module jls_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [jls_pkg::DVD_W-1:0]   dvd_i,
  input  wire logic [jls_pkg::DATA_W-1:0]  dvs_i,
  output logic                             done_o,
  output logic      [jls_pkg::DVD_W-1:0]   quo_o
);
  import jls_pkg::*;

  logic              run_q, run_d, done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  // One quotient bit per cycle, restoring.
  always_comb begin
    rem_sh = {rem_q[DATA_W-1:0], quo_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DVD_W);
      quo_d = dvd_i;
      rem_d = '0;
      dvs_d = dvs_i;
    end else if (run_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

/* src/jls_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module jls_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire jls_pkg::req_t               req_i,
  input  wire logic [jls_pkg::SIZE_W-1:0]  sys_size_i,
  input  wire logic [jls_pkg::ITER_W-1:0]  iter_limit_i,
  input  wire jls_pkg::dp_stat_t           stat_i,
  output logic                             busy,
  output jls_pkg::ctrl_cmd_t               cmd_o
);
  import jls_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIAG  = 4'd1;
  localparam logic [3:0] S_DWAIT = 4'd2;
  localparam logic [3:0] S_ROW   = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d;
  logic [ITER_W-1:0] sweep_q, sweep_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [IDX_W-1:0]  last_idx;
  logic [ITER_W-1:0] limit;

  always_comb begin
    if (sys_size_i == '0) begin
      last_idx = '0;
    end else if (sys_size_i > SIZE_W'(MAX_N)) begin
      last_idx = IDX_W'(MAX_N - 1);
    end else begin
      last_idx = IDX_W'(sys_size_i - SIZE_W'(1));
    end
    limit = (iter_limit_i == '0) ? ITER_W'(1) : iter_limit_i;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    sweep_d = sweep_q;
    stat_d  = stat_q;
    cmd_o   = '0;
    cmd_o.stat  = stat_q;
    cmd_o.iters = sweep_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.cmd == CMD_SOLVE) begin
            cmd_o.clr_solve = 1'b1;
            sweep_d = '0;
            i_d     = '0;
            state_d = S_DIAG;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_DIAG: begin
        cmd_o.diag_rd = 1'b1;
        cmd_o.row_idx = i_q;
        cmd_o.col_idx = i_q;
        if (i_q == last_idx) begin
          state_d = S_DWAIT;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      S_DWAIT: begin
        i_d = '0;
        j_d = '0;
        if (stat_i.zero_diag) begin
          stat_d  = ST_ZERO_DIAG;
          state_d = S_OUT;
        end else begin
          cmd_o.clr_worst = 1'b1;
          sweep_d = ITER_W'(1);
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_rd  = 1'b1;
        cmd_o.row_idx = i_q;
        cmd_o.col_idx = j_q;
        if (j_q == last_idx) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (stat_i.pipe_empty) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd     = 1'b1;
        cmd_o.row_idx = i_q;
        j_d = '0;
        if (i_q == last_idx) begin
          state_d = S_EVAL;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_ROW;
        end
      end
      S_EVAL: begin
        cmd_o.flip = 1'b1;
        i_d = '0;
        j_d = '0;
        if (stat_i.converged) begin
          stat_d  = ST_CONVERGED;
          state_d = S_OUT;
        end else if (sweep_q >= limit) begin
          stat_d  = ST_LIMIT;
          state_d = S_OUT;
        end else begin
          cmd_o.clr_worst = 1'b1;
          sweep_d = sweep_q + ITER_W'(1);
          state_d = S_ROW;
        end
      end
      S_OUT: begin
        cmd_o.out_rd   = 1'b1;
        cmd_o.col_idx  = j_q;
        cmd_o.out_last = (j_q == last_idx);
        if (j_q == last_idx) begin
          state_d = S_IDLE;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      sweep_q <= '0;
      stat_q  <= ST_CONVERGED;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      sweep_q <= sweep_d;
      stat_q  <= stat_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* src/jls_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module jls_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire jls_pkg::req_t              req_i,
  input  wire jls_pkg::ctrl_cmd_t         cmd_i,
  input  wire logic [jls_pkg::TOL_W-1:0]  tol_i,
  output jls_pkg::dp_stat_t               stat_o,
  output logic                            res_valid_o,
  output jls_pkg::res_t                   res_o
);
  import jls_pkg::*;

  logic                     ld_mat, ld_rhs, ld_x;
  logic signed [DATA_W-1:0] mat_rd, rhs_rd, x0_rd, x1_rd, x_rd;
  logic                     x0_we, x1_we;
  logic [IDX_W-1:0]         x_waddr;
  logic signed [DATA_W-1:0] x_wdata;

  logic [MAX_N-1:0]         sel_q, upd_mask_q;
  logic                     s1_row_q, s1_diag_q, s1_out_q, s1_last_q;
  logic [IDX_W-1:0]         s1_ri_q, s1_ci_q;
  logic [STAT_W-1:0]        s1_stat_q;
  logic [ITER_W-1:0]        s1_iters_q;
  logic signed [63:0]       p_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W-1:0] diag_q, xi_q;
  logic                     zd_q, neg_q;
  logic [DATA_W:0]          worst_q;
  logic                     res_valid_q;
  res_t                     res_q;

  logic signed [DATA_W-1:0] term, acc_sat, new_val;
  logic [DATA_W-1:0]        acc_mag, dvs_mag;
  logic                     div_done;
  logic [DVD_W-1:0]         quo;
  logic signed [DVD_W:0]    quo_s;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          adiff;
  logic                     zero_now;

  assign ld_mat = cmd_i.load && (req_i.cmd == CMD_LD_MAT);
  assign ld_rhs = cmd_i.load && (req_i.cmd == CMD_LD_RHS);
  assign ld_x   = cmd_i.load && (req_i.cmd == CMD_LD_X);

  // Each element keeps its own bank select. Guess loads go to the selected bank,
  // sweep results to the other one; the selects of updated rows swap per sweep.
  assign x0_we   = (ld_x && !sel_q[req_i.row]) || (cmd_i.upd && sel_q[cmd_i.row_idx]);
  assign x1_we   = (ld_x && sel_q[req_i.row]) || (cmd_i.upd && !sel_q[cmd_i.row_idx]);
  assign x_waddr = cmd_i.upd ? cmd_i.row_idx : req_i.row;
  assign x_wdata = cmd_i.upd ? new_val : req_i.value;

  jls_ram #(.Width(DATA_W), .Depth(MAX_N * MAX_N)) u_mat (
    .clk_i, .we_i(ld_mat), .waddr_i({req_i.row, req_i.col}), .wdata_i(req_i.value),
    .raddr_i({cmd_i.row_idx, cmd_i.col_idx}), .rdata_o(mat_rd)
  );
  jls_ram #(.Width(DATA_W), .Depth(MAX_N)) u_rhs (
    .clk_i, .we_i(ld_rhs), .waddr_i(req_i.row), .wdata_i(req_i.value),
    .raddr_i(cmd_i.row_idx), .rdata_o(rhs_rd)
  );
  jls_ram #(.Width(DATA_W), .Depth(MAX_N)) u_x0 (
    .clk_i, .we_i(x0_we), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .raddr_i(cmd_i.col_idx), .rdata_o(x0_rd)
  );
  jls_ram #(.Width(DATA_W), .Depth(MAX_N)) u_x1 (
    .clk_i, .we_i(x1_we), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .raddr_i(cmd_i.col_idx), .rdata_o(x1_rd)
  );

  assign x_rd = sel_q[s1_ci_q] ? x1_rd : x0_rd;

  assign term    = sat32(p_q >>> FRAC_BITS);
  assign acc_sat = sat32(64'(acc_q));
  assign acc_mag = acc_sat[DATA_W-1] ? (DATA_W'(~acc_sat) + DATA_W'(1)) : DATA_W'(acc_sat);
  assign dvs_mag = diag_q[DATA_W-1] ? (DATA_W'(~diag_q) + DATA_W'(1)) : DATA_W'(diag_q);

  jls_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .dvd_i({acc_mag, {FRAC_BITS{1'b0}}}), .dvs_i(dvs_mag),
    .done_o(div_done), .quo_o(quo)
  );

  assign quo_s   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign new_val = sat32(64'(quo_s));
  assign diff    = (DATA_W+1)'(new_val) - (DATA_W+1)'(xi_q);
  assign adiff   = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
  assign zero_now = s1_diag_q && (mat_rd == '0);

  assign stat_o.zero_diag  = zd_q || zero_now;
  assign stat_o.pipe_empty = !s1_row_q && !pv_q;
  assign stat_o.div_done   = div_done;
  assign stat_o.converged  = (worst_q <= (DATA_W+1)'(tol_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      upd_mask_q  <= '0;
      s1_row_q    <= 1'b0;
      s1_diag_q   <= 1'b0;
      s1_out_q    <= 1'b0;
      pv_q        <= 1'b0;
      zd_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_row_q    <= cmd_i.row_rd;
      s1_diag_q   <= cmd_i.diag_rd;
      s1_out_q    <= cmd_i.out_rd;
      pv_q        <= s1_row_q && (s1_ci_q != s1_ri_q);
      res_valid_q <= s1_out_q;
      if (cmd_i.flip) begin
        sel_q      <= sel_q ^ upd_mask_q;
        upd_mask_q <= '0;
      end else if (cmd_i.upd) begin
        upd_mask_q[cmd_i.row_idx] <= 1'b1;
      end
      if (cmd_i.clr_solve) begin
        zd_q <= 1'b0;
      end else if (zero_now) begin
        zd_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ri_q    <= cmd_i.row_idx;
    s1_ci_q    <= cmd_i.col_idx;
    s1_last_q  <= cmd_i.out_last;
    s1_stat_q  <= cmd_i.stat;
    s1_iters_q <= cmd_i.iters;
    p_q        <= mat_rd * x_rd;
    if (s1_row_q && (s1_ci_q == s1_ri_q)) begin
      diag_q <= mat_rd;
      xi_q   <= x_rd;
    end
    // Seed with b_i on the first column, then subtract each off-diagonal term.
    if (s1_row_q && (s1_ci_q == '0)) begin
      acc_q <= ACC_W'(rhs_rd);
    end else if (pv_q) begin
      acc_q <= acc_q - ACC_W'(term);
    end
    if (cmd_i.div_start) begin
      neg_q <= acc_sat[DATA_W-1] ^ diag_q[DATA_W-1];
    end
    if (cmd_i.clr_worst) begin
      worst_q <= '0;
    end else if (cmd_i.upd && (adiff > worst_q)) begin
      worst_q <= adiff;
    end
    res_q.index      <= s1_ci_q;
    res_q.solution   <= (s1_stat_q == ST_ZERO_DIAG) ? '0 : x_rd;
    res_q.iterations <= s1_iters_q;
    res_q.status     <= s1_stat_q;
    res_q.last       <= s1_last_q;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

/* src/jacobi_linear_solver_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Jacobi solver for A x = b, signed Q16.16. Load requests are taken while idle.
// Solve: n diagonal reads, then per sweep n rows of n multiply-accumulate reads
// and a bit-serial divide each, plus n results; all rows share one divider,
// which dominates the sweep time. Results are one-cycle strobes that the
// receiver must take. Reset (async, active low) clears control and loads the
// register defaults; the matrix and vectors are undefined until loaded.
module jacobi_linear_solver_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire jls_pkg::req_t                  req_i,
  output logic                                busy,
  input  wire logic                           cfg_we_i,
  input  wire logic [jls_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [jls_pkg::TOL_W-1:0]      cfg_data_i,
  output logic                                res_valid_o,
  output jls_pkg::res_t                       res_o
);
  import jls_pkg::*;

  // Config regs: user writes only while the solver is idle; block does not check.
  logic [SIZE_W-1:0] size_q;
  logic [TOL_W-1:0]  tol_q;
  logic [ITER_W-1:0] limit_q;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Hold the registers until a write selects one; drop writes to unused indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_W'(10);
      tol_q   <= TOL_W'(66);
      limit_q <= ITER_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_TOL:   tol_q   <= cfg_data_i;
        CFG_LIMIT: limit_q <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: walks the diagonal check, the row sweeps and the result run.
  jls_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .req_i,
    .sys_size_i(size_q), .iter_limit_i(limit_q),
    .stat_i(stat), .busy, .cmd_o(cmd)
  );

  // Datapath: stores, multiply-accumulate, divider, change tracking, result register.
  jls_dp u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .tol_i(tol_q),
    .stat_o(stat), .res_valid_o, .res_o
  );

endmodule
`default_nettype wire

/* src/jls_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "jacobi_linear_solver_top_assert.svh"
module jls_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire jls_pkg::req_t req_i,
  input wire logic          busy,
  input wire logic          res_valid_o,
  input wire jls_pkg::res_t res_o
);
  import jls_pkg::*;

  `JLS_ASSERT(a_solve_busy, (start && !busy && req_i.cmd == CMD_SOLVE) |=> busy, "solve did not go busy")
  `JLS_ASSERT(a_load_quick, (start && !busy && req_i.cmd != CMD_SOLVE) |=> !busy, "load went busy")
  `JLS_ASSERT(a_run_next, (res_valid_o && !res_o.last) |=> (res_valid_o && res_o.index == 4'($past(res_o.index) + 4'd1)), "result run broke")
  `JLS_ASSERT(a_zero_diag, (res_valid_o && res_o.status == ST_ZERO_DIAG) |-> (res_o.solution == 0 && res_o.iterations == 0), "bad zero-diagonal result")
  `JLS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> (!res_valid_o || rst_ni), "result after reset")

endmodule

bind jacobi_linear_solver_top jls_checker u_jls_checker (.*);
`default_nettype wire

/* tb/jacobi_linear_solver_top_tb.sv */
`timescale 1ns / 1ps
module jacobi_linear_solver_top_tb;
  import jls_pkg::*;

  // Stalled-cycle bound: the slowest solve here is well under this.
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    req_t r;
    bit   drain;   // hold this request until every result has come back
  } pend_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  req_t                 req_i = '0;
  logic                 busy;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [TOL_W-1:0]     cfg_data_i = '0;
  logic                 res_valid_o;
  res_t                 res_o;

  jacobi_linear_solver_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Solver shadow state, updated as requests are accepted.
  longint          mat_q[MAX_N][MAX_N];
  longint          rhs_q[MAX_N];
  longint          x_old[MAX_N];
  longint          x_new[MAX_N];
  logic [SIZE_W-1:0] size_reg = 5'd10;
  logic [TOL_W-1:0]  tol_reg = 31'd66;
  logic [ITER_W-1:0] lim_reg = 16'd1000;

  // Stimulus-side bookkeeping: which entries are queued to be written so far.
  bit  mat_set[MAX_N][MAX_N];
  bit  rhs_set[MAX_N];
  bit  x_set[MAX_N];
  int  gen_n;

  pend_t pend_q[$];
  res_t  solution_q[$];
  int    idle_pct = 0;
  int    n_reqs = 0, n_solves = 0, n_results = 0, n_errs = 0;
  int    stall_cnt = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int size_in_use(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_N) return MAX_N;
    return int'(s);
  endfunction

  // Run one accepted request through the shadow solver; a solve queues its results.
  function automatic void solve_step(req_t r);
    int     n;
    longint acc, worst, diff;
    bit     zdiag;
    logic [ITER_W-1:0] sweeps;
    logic [STAT_W-1:0] st;
    int     lim;
    res_t   o;
    case (r.cmd)
      CMD_LD_MAT: mat_q[r.row][r.col] = longint'(r.value);
      CMD_LD_RHS: rhs_q[r.row] = longint'(r.value);
      CMD_LD_X:   x_old[r.row] = longint'(r.value);
      default: begin
        n = size_in_use(size_reg);
        lim = (lim_reg == 0) ? 1 : int'(lim_reg);
        zdiag = 1'b0;
        sweeps = '0;
        for (int i = 0; i < n; i++) if (mat_q[i][i] == 0) zdiag = 1'b1;
        if (zdiag) begin
          st = ST_ZERO_DIAG;
        end else begin
          forever begin
            worst = 0;
            sweeps++;
            for (int i = 0; i < n; i++) begin
              acc = rhs_q[i];
              for (int j = 0; j < n; j++)
                if (j != i) acc -= clamp32((mat_q[i][j] * x_old[j]) >>> FRAC_BITS);
              acc = clamp32(acc);
              x_new[i] = clamp32((acc * 65536) / mat_q[i][i]);
            end
            for (int i = 0; i < n; i++) begin
              diff = x_new[i] - x_old[i];
              if (diff < 0) diff = -diff;
              if (diff > worst) worst = diff;
            end
            for (int i = 0; i < n; i++) x_old[i] = x_new[i];
            if (worst <= longint'(tol_reg)) begin
              st = ST_CONVERGED;
              break;
            end
            if (int'(sweeps) >= lim) begin
              st = ST_LIMIT;
              break;
            end
          end
        end
        for (int k = 0; k < n; k++) begin
          o.index = k[IDX_W-1:0];
          o.solution = zdiag ? '0 : x_new[k][DATA_W-1:0];
          o.iterations = sweeps;
          o.status = st;
          o.last = (k == n - 1);
          solution_q.insert(solution_q.size(), o);
        end
        n_solves++;
      end
    endcase
  endfunction

  // Driver: take the accepted request, then offer the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        solve_step(req_i);
        n_reqs++;
      end
      if (!start || !busy) begin
        if (pend_q.size() > 0 && !(pend_q[0].drain && solution_q.size() > 0)
            && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          req_i <= pend_q.pop_front().r;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (solution_q.size() == 0) begin
        n_errs++;
        if (n_errs <= 10) $display("unexpected result %p", res_o);
      end else begin
        res_t exp_r;
        exp_r = solution_q.pop_front();
        if (res_o.index !== exp_r.index || res_o.solution !== exp_r.solution
            || res_o.iterations !== exp_r.iterations || res_o.status !== exp_r.status
            || res_o.last !== exp_r.last) begin
          n_errs++;
          if (n_errs <= 10) $display("mismatch: expected %p got %p", exp_r, res_o);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing is accepted and no result arrives.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || !rst_ni) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog expired, %0d results still pending", solution_q.size());
      $display("[jacobi_linear_solver_top] ERROR");
      $finish;
    end
  end

  task automatic push_req(logic [CMD_W-1:0] c, int r, int cl, logic [31:0] v,
                          bit drain = 1'b0);
    pend_t p;
    p.r.cmd = c;
    p.r.row = r[IDX_W-1:0];
    p.r.col = cl[IDX_W-1:0];
    p.r.value = v;
    p.drain = drain;
    pend_q.insert(pend_q.size(), p);
    case (c)
      CMD_LD_MAT: mat_set[r][cl] = 1'b1;
      CMD_LD_RHS: rhs_set[r] = 1'b1;
      CMD_LD_X:   x_set[r] = 1'b1;
      default: for (int i = 0; i < gen_n; i++) x_set[i] = 1'b1;
    endcase
  endtask

  function automatic logic [31:0] small_val(int mag);
    return $urandom_range(2 * mag) - mag;
  endfunction

  // Load a diagonally dominant system of the current size, with rhs and, if asked or unset, a guess.
  task automatic load_system(bit guess);
    int sum;
    logic [31:0] d;
    for (int i = 0; i < gen_n; i++) begin
      sum = 0;
      for (int j = 0; j < gen_n; j++) begin
        if (j != i) begin
          d = small_val(131072);
          sum += ($signed(d) < 0) ? -$signed(d) : $signed(d);
          push_req(CMD_LD_MAT, i, j, d);
        end
      end
      d = sum + $urandom_range(1 << 20, 65536);
      if ($urandom_range(1)) d = -d;
      push_req(CMD_LD_MAT, i, i, d);
      push_req(CMD_LD_RHS, i, 0, small_val(1 << 22));
      if (guess || !x_set[i]) push_req(CMD_LD_X, i, 0, small_val(1 << 20));
    end
  endtask

  function automatic bit all_set();
    for (int i = 0; i < gen_n; i++) begin
      if (!rhs_set[i] || !x_set[i]) return 1'b0;
      for (int j = 0; j < gen_n; j++) if (!mat_set[i][j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Wait until the driver has drained its queue and every result is in.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pend_q.size() > 0 || start || solution_q.size() > 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SIZE:  size_reg = data[SIZE_W-1:0];
      CFG_TOL:   tol_reg = data;
      CFG_LIMIT: lim_reg = data[ITER_W-1:0];
      default: ;
    endcase
    gen_n = size_in_use(size_reg);
  endtask

  initial begin
    int pick;
    gen_n = 10;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full 16x16 system under loose tolerance and the largest sweep limit.
    write_reg(CFG_SIZE, 31'd16);
    write_reg(CFG_TOL, 31'h7FFFFFFF);
    write_reg(CFG_LIMIT, 31'd65535);
    load_system(1'b1);
    push_req(CMD_SOLVE, 0, 0, '0);
    wait_idle();

    // Sizes above the array act as the full array; two sweeps, no tolerance.
    write_reg(CFG_SIZE, 31'd31);
    write_reg(CFG_TOL, 31'd0);
    write_reg(CFG_LIMIT, 31'd2);
    push_req(CMD_SOLVE, 0, 0, '0);
    wait_idle();

    // Size zero acts as one; sweep limit zero acts as one.
    write_reg(CFG_SIZE, 31'd0);
    write_reg(CFG_LIMIT, 31'd0);
    push_req(CMD_LD_MAT, 0, 0, 32'd1);
    push_req(CMD_LD_RHS, 0, 0, 32'h7FFFFFFF);
    push_req(CMD_SOLVE, 0, 0, '0);
    push_req(CMD_LD_RHS, 0, 0, 32'h80000000);
    push_req(CMD_LD_X, 0, 0, 32'h80000000);
    push_req(CMD_SOLVE, 0, 0, '0);
    push_req(CMD_LD_MAT, 0, 0, 32'h80000000);
    push_req(CMD_LD_X, 0, 0, 32'h7FFFFFFF);
    push_req(CMD_SOLVE, 0, 0, '0);
    // Zero diagonal: no sweep, zero solutions, vectors untouched.
    push_req(CMD_LD_MAT, 0, 0, 32'd0);
    push_req(CMD_SOLVE, 0, 0, '0);
    push_req(CMD_LD_MAT, 0, 0, 32'hFFFFFFFF);
    push_req(CMD_SOLVE, 0, 0, '0, 1'b1);
    push_req(CMD_LD_MAT, 15, 15, 32'h7FFFFFFF);
    push_req(CMD_LD_RHS, 15, 0, 32'h12345678);
    wait_idle();

    // Random part: three pacing modes, two register settings each.
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 22 : (phase < 4) ? 57 : 0;
      write_reg(CFG_SIZE, $urandom_range(4) + (phase == 5 ? 2 : 0));
      pick = $urandom_range(2);
      write_reg(CFG_TOL, pick == 0 ? 31'd0 : pick == 1 ? $urandom_range(4096)
                                       : $urandom_range(31'h7FFFFFFF, 31'h100000));
      write_reg(CFG_LIMIT, $urandom_range(40, 1));
      for (int k = 0; k < 16; ) begin
        if ($urandom_range(99) < 70) begin
          k += gen_n * (gen_n + 2) + 1;
          load_system($urandom_range(1));
          push_req(CMD_SOLVE, 0, 0, '0, $urandom_range(9) == 0);
        end else begin
          k += 3;
          repeat (3) begin
            pick = $urandom_range(2);
            push_req(pick[CMD_W-1:0], $urandom_range(15), $urandom_range(15), $urandom);
          end
          if (all_set()) push_req(CMD_SOLVE, 0, 0, $urandom, 1'b1);
        end
      end
      wait_idle();
    end

    $display("covered %0d requests, %0d solves, %0d result elements checked",
             n_reqs, n_solves, n_results);
    $display("sizes 0 to 31, tolerance and sweep limits at both ends, zero diagonal");
    if (n_errs == 0 && solution_q.size() == 0) begin
      $display("[jacobi_linear_solver_top] OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_errs, solution_q.size());
      $display("[jacobi_linear_solver_top] ERROR");
    end
    $finish;
  end

endmodule
